FILE: rtl/ffsa_pkg.sv
// Package for the first-free slot allocator.
// Field widths, operation and status codes, config register map, shared types.
// No dependencies.
package ffsa_pkg;

    localparam int MODE_W  = 2;
    localparam int SLOT_W  = 8;
    localparam int TAG_W   = 64;
    localparam int STAT_W  = 3;
    localparam int CNT_W   = 7;
    localparam int RAM_W   = TAG_W + 1;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [MODE_W-1:0] MODE_ALLOC    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_REL_SLOT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_REL_TAG  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_CLEAR    = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
    localparam logic [STAT_W-1:0] ST_FULL      = 3'd1;
    localparam logic [STAT_W-1:0] ST_RANGE     = 3'd2;
    localparam logic [STAT_W-1:0] ST_FREE      = 3'd3;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd4;

    // register index lives in paddr[2]
    localparam logic REG_SLOTS_IN_USE = 1'b0;
    localparam logic [CNT_W-1:0] SLOTS_RESET = 7'd64;

    typedef struct packed {
        logic             wr;  // slots_in_use written this cycle
        logic [CNT_W-1:0] n;   // effective slot count
    } t_cfg_ctl;

endpackage

FILE: rtl/ffsa_if.sv
// Request and response channel interfaces of the slot allocator.
// Depends on ffsa_pkg.
interface ffsa_req_if;
    import ffsa_pkg::*;
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [SLOT_W-1:0] slot_number;
    logic [TAG_W-1:0]  owner_tag;
    modport source (output valid, mode, slot_number, owner_tag, input ready);
    modport sink   (input valid, mode, slot_number, owner_tag, output ready);
endinterface

interface ffsa_rsp_if;
    import ffsa_pkg::*;
    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [CNT_W-1:0]  slot_result;
    logic [TAG_W-1:0]  released_tag;
    logic [CNT_W-1:0]  free_slots;
    modport source (output valid, status, slot_result, released_tag, free_slots,
                    input ready);
    modport sink   (input valid, status, slot_result, released_tag, free_slots,
                    output ready);
endinterface

FILE: rtl/ffsa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ffsa_ram #(
    parameter int WIDTH = 65,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/ffsa_cfg.sv
// APB register block: holds slots_in_use, derives the effective slot count.
// Depends on ffsa_pkg.
module ffsa_cfg #(
    parameter int MAX_SLOTS = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ffsa_pkg::PADDR_W-1:0]   paddr,
    input  logic [ffsa_pkg::PDATA_W-1:0]   pwdata,
    output logic [ffsa_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready,
    output ffsa_pkg::t_cfg_ctl             o_ctl
);
    import ffsa_pkg::*;

    localparam int CAP = (MAX_SLOTS < 127) ? MAX_SLOTS : 127;
    localparam logic [CNT_W-1:0] CAP_N = CNT_W'(CAP);

    logic [CNT_W-1:0] r_siu;
    logic             wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_SLOTS_IN_USE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_siu <= SLOTS_RESET;
        end else if (wr_en) begin
            r_siu <= pwdata[CNT_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_SLOTS_IN_USE) ? PDATA_W'(r_siu) : '0;

    always_comb begin
        o_ctl.wr = wr_en;
        priority if (r_siu == '0) begin
            o_ctl.n = CNT_W'(1);
        end else if (r_siu > CAP_N) begin
            o_ctl.n = CAP_N;
        end else begin
            o_ctl.n = r_siu;
        end
    end

endmodule

FILE: rtl/ffsa_seq.sv
// Sequencer: scans the slot RAM one entry a cycle through a shared compare,
// handles release by slot, clearing sweeps and the response register.
// Depends on ffsa_pkg, ffsa_if.
module ffsa_seq #(
    parameter int MAX_SLOTS = 64,
    localparam int AW       = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  ffsa_pkg::t_cfg_ctl           i_ctl,
    ffsa_req_if.sink                     i_req,
    ffsa_rsp_if.source                   o_rsp,
    output logic                         o_ram_we,
    output logic [AW-1:0]                o_ram_waddr,
    output logic [ffsa_pkg::RAM_W-1:0]   o_ram_wdata,
    output logic                         o_ram_re,
    output logic [AW-1:0]                o_ram_raddr,
    input  logic [ffsa_pkg::RAM_W-1:0]   i_ram_rdata
);
    import ffsa_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_REL  = 6'b000010,
        S_RCHK = 6'b000100,
        S_SCAN = 6'b001000,
        S_CLR  = 6'b010000,
        S_PUSH = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic [MODE_W-1:0] r_mode, n_mode;
    logic [SLOT_W-1:0] r_slot, n_slot;
    logic [TAG_W-1:0]  r_tag, n_tag;
    logic [CNT_W-1:0]  r_free, n_free;
    logic [CNT_W-1:0]  r_idx, n_idx;
    logic              r_chk_vld, n_chk_vld;
    logic [CNT_W-1:0]  r_chk_idx, n_chk_idx;
    logic              r_report, n_report;
    logic [STAT_W-1:0] r_res_stat, n_res_stat;
    logic [CNT_W-1:0]  r_res_slot, n_res_slot;
    logic [TAG_W-1:0]  r_res_tag, n_res_tag;
    logic [CNT_W-1:0]  r_res_free, n_res_free;
    logic              r_ovalid, n_ovalid;
    logic [STAT_W-1:0] r_ostat, n_ostat;
    logic [CNT_W-1:0]  r_oslot, n_oslot;
    logic [TAG_W-1:0]  r_otag, n_otag;
    logic [CNT_W-1:0]  r_ofree, n_ofree;

    logic             rd_taken;
    logic [TAG_W-1:0] rd_owner;
    logic             hit;
    logic             last;
    logic [CNT_W-1:0] n_m1;
    logic [SLOT_W-1:0] slot_m1;

    assign rd_taken = i_ram_rdata[TAG_W];
    assign rd_owner = i_ram_rdata[TAG_W-1:0];
    assign n_m1     = i_ctl.n - CNT_W'(1);
    assign slot_m1  = r_slot - SLOT_W'(1);
    assign last     = (r_chk_idx == n_m1);
    // shared compare: free entry for allocate, owned and matching for tag release
    assign hit = (r_mode == MODE_ALLOC) ? !rd_taken : (rd_taken && (rd_owner == r_tag));

    assign i_req.ready        = (r_state == S_IDLE) && !i_ctl.wr;
    assign o_rsp.valid        = r_ovalid;
    assign o_rsp.status       = r_ostat;
    assign o_rsp.slot_result  = r_oslot;
    assign o_rsp.released_tag = r_otag;
    assign o_rsp.free_slots   = r_ofree;

    always_comb begin
        n_state    = r_state;
        n_mode     = r_mode;
        n_slot     = r_slot;
        n_tag      = r_tag;
        n_free     = r_free;
        n_idx      = r_idx;
        n_chk_vld  = r_chk_vld;
        n_chk_idx  = r_chk_idx;
        n_report   = r_report;
        n_res_stat = r_res_stat;
        n_res_slot = r_res_slot;
        n_res_tag  = r_res_tag;
        n_res_free = r_res_free;
        n_ovalid   = r_ovalid && !o_rsp.ready;
        n_ostat    = r_ostat;
        n_oslot    = r_oslot;
        n_otag     = r_otag;
        n_ofree    = r_ofree;
        o_ram_we    = 1'b0;
        o_ram_waddr = AW'(r_chk_idx);
        o_ram_wdata = '0;
        o_ram_re    = 1'b0;
        o_ram_raddr = AW'(r_idx);

        if (i_ctl.wr) begin
            n_state  = S_CLR;
            n_idx    = '0;
            n_report = 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        n_mode     = i_req.mode;
                        n_slot     = i_req.slot_number;
                        n_tag      = i_req.owner_tag;
                        n_idx      = '0;
                        n_chk_vld  = 1'b0;
                        n_res_stat = ST_OK;
                        n_res_slot = '0;
                        n_res_tag  = '0;
                        n_res_free = r_free;
                        unique case (i_req.mode)
                            MODE_ALLOC: begin
                                if (r_free == '0) begin
                                    n_res_stat = ST_FULL;
                                    n_state    = S_PUSH;
                                end else begin
                                    n_state = S_SCAN;
                                end
                            end
                            MODE_REL_SLOT: n_state = S_REL;
                            MODE_REL_TAG:  n_state = S_SCAN;
                            MODE_CLEAR: begin
                                n_state  = S_CLR;
                                n_report = 1'b1;
                            end
                            default: n_state = S_IDLE;
                        endcase
                    end
                end
                S_REL: begin
                    if ((r_slot == '0) || (r_slot > {1'b0, i_ctl.n})) begin
                        n_res_stat = ST_RANGE;
                        n_state    = S_PUSH;
                    end else begin
                        o_ram_re    = 1'b1;
                        o_ram_raddr = AW'(slot_m1);
                        n_state     = S_RCHK;
                    end
                end
                S_RCHK: begin
                    if (!rd_taken) begin
                        n_res_stat = ST_FREE;
                    end else begin
                        o_ram_we    = 1'b1;
                        o_ram_waddr = AW'(slot_m1);
                        n_free      = r_free + CNT_W'(1);
                        n_res_slot  = CNT_W'(r_slot);
                        n_res_tag   = rd_owner;
                        n_res_free  = r_free + CNT_W'(1);
                    end
                    n_state = S_PUSH;
                end
                S_SCAN: begin
                    n_chk_vld = (r_idx < i_ctl.n);
                    n_chk_idx = r_idx;
                    if (r_idx < i_ctl.n) begin
                        o_ram_re = 1'b1;
                        n_idx    = r_idx + CNT_W'(1);
                    end
                    if (r_chk_vld) begin
                        if (hit) begin
                            o_ram_we   = 1'b1;
                            n_res_slot = r_chk_idx + CNT_W'(1);
                            n_state    = S_PUSH;
                            if (r_mode == MODE_ALLOC) begin
                                o_ram_wdata = {1'b1, r_tag};
                                n_free      = r_free - CNT_W'(1);
                                n_res_free  = r_free - CNT_W'(1);
                            end else begin
                                n_free     = r_free + CNT_W'(1);
                                n_res_free = r_free + CNT_W'(1);
                                n_res_tag  = r_tag;
                            end
                        end else if (last) begin
                            n_res_stat = (r_mode == MODE_ALLOC) ? ST_FULL : ST_NOT_FOUND;
                            n_state    = S_PUSH;
                        end
                    end
                end
                S_CLR: begin
                    o_ram_we    = 1'b1;
                    o_ram_waddr = AW'(r_idx);
                    n_idx       = r_idx + CNT_W'(1);
                    if (r_idx == n_m1) begin
                        n_free     = i_ctl.n;
                        n_res_stat = ST_OK;
                        n_res_slot = '0;
                        n_res_tag  = '0;
                        n_res_free = i_ctl.n;
                        n_state    = r_report ? S_PUSH : S_IDLE;
                    end
                end
                S_PUSH: begin
                    if (!r_ovalid || o_rsp.ready) begin
                        n_ovalid = 1'b1;
                        n_ostat  = r_res_stat;
                        n_oslot  = r_res_slot;
                        n_otag   = r_res_tag;
                        n_ofree  = r_res_free;
                        n_state  = S_IDLE;
                    end
                end
                default: n_state = S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_idx     <= '0;
            r_report  <= 1'b0;
            r_chk_vld <= 1'b0;
            r_free    <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_idx     <= n_idx;
            r_report  <= n_report;
            r_chk_vld <= n_chk_vld;
            r_free    <= n_free;
            r_ovalid  <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode     <= n_mode;
        r_slot     <= n_slot;
        r_tag      <= n_tag;
        r_chk_idx  <= n_chk_idx;
        r_res_stat <= n_res_stat;
        r_res_slot <= n_res_slot;
        r_res_tag  <= n_res_tag;
        r_res_free <= n_res_free;
        r_ostat    <= n_ostat;
        r_oslot    <= n_oslot;
        r_otag     <= n_otag;
        r_ofree    <= n_ofree;
    end

    a_free_le_n: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_free <= i_ctl.n))
        else $error("free count above slot count");

    a_we_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ram_we |-> ((r_state == S_SCAN) || (r_state == S_RCHK) || (r_state == S_CLR)))
        else $error("slot RAM written outside a write state");

    a_alloc_finds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !((r_state == S_SCAN) && r_chk_vld && !hit && last && (r_mode == MODE_ALLOC)
          && !i_ctl.wr))
        else $error("allocate scan ran out with free slots counted");

    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> (r_state != S_IDLE))
        else $error("request accepted but sequencer stayed idle");

endmodule

FILE: rtl/first_free_slot_allocator.sv
// Top level of the first-free slot allocator: APB registers, sequencer, slot RAM.
// Depends on ffsa_pkg, ffsa_if, ffsa_cfg, ffsa_seq, ffsa_ram.
//
//  channel   dir  handshake        payload
//  i_req     in   valid/ready      mode, slot_number, owner_tag
//  o_rsp     out  valid/ready      status, slot_result, released_tag, free_slots
//  apb       in   psel/penable     paddr, pwdata -> prdata (slots_in_use at 0x0)
//
// n = effective slot count. Allocate and release by tag scan the slot RAM one
// entry per cycle. Reset and each slots_in_use write start a clearing sweep of
// all n RAM entries with i_req.ready low. A finished response waits in the output
// register; the next request is accepted while it waits.
module first_free_slot_allocator #(
    parameter int MAX_SLOTS = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    ffsa_req_if.sink                      i_req,
    ffsa_rsp_if.source                    o_rsp,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ffsa_pkg::PADDR_W-1:0]  paddr,
    input  logic [ffsa_pkg::PDATA_W-1:0]  pwdata,
    output logic [ffsa_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);
    import ffsa_pkg::*;

    localparam int AW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

    t_cfg_ctl         ctl;
    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [RAM_W-1:0] ram_wdata;
    logic             ram_re;
    logic [AW-1:0]    ram_raddr;
    logic [RAM_W-1:0] ram_rdata;

    ffsa_cfg #(.MAX_SLOTS(MAX_SLOTS)) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_ctl   (ctl)
    );

    ffsa_seq #(.MAX_SLOTS(MAX_SLOTS)) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .i_req       (i_req),
        .o_rsp       (o_rsp),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_re    (ram_re),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata)
    );

    ffsa_ram #(.WIDTH(RAM_W), .DEPTH(MAX_SLOTS)) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

endmodule
